@@ sv/jcq_pkg.sv @@
// Shared types and constants for the jump chain exit query block.
package jcq_pkg;

	localparam int FIELD_W        = 9;
	localparam int MAX_HOLES_DEF  = 256;
	localparam int BLOCK_SIZE_DEF = 16;
	localparam int HC_RESET       = 256;

	localparam logic REQ_SET   = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	typedef struct packed {
		logic               req_type;
		logic [FIELD_W-1:0] position;
		logic [FIELD_W-1:0] power;
	} req_t;

	typedef struct packed {
		logic [FIELD_W-1:0] last_hole;
		logic [FIELD_W-1:0] jump_count;
		logic               error;
	} rsp_t;

	typedef logic [FIELD_W-1:0] cfg_t;

endpackage

@@ sv/jcq_stream_if.sv @@
// Valid/ready channel carrying one payload per request.
interface jcq_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ sv/jump_chain_exit_query.sv @@
// Jump chain exit query: hole row with per-block jump summaries.
// Channels: req (sink) takes set-power or query requests, rsp (source) returns
// one result per query, cfg (sink) writes hole_count and starts a full rebuild.
// After reset the block sets every power memory entry to 1, one entry a cycle,
// then rebuilds all summaries; req and cfg are not ready until then.
// An update steps the block start forward until it covers the updated hole,
// then rebuilds that block hole by hole (power read, summary read, write).
// A config write rebuilds every block.
// A query visits one block summary after another (registered memory read,
// then accumulate). An out-of-range query goes straight to the result
// with error set.
// One request is in work at a time; req is ready only in the idle state.
// Results sit in an output register; if rsp stalls, the next request is still
// taken, and a finished query waits for that register to drain.
module jump_chain_exit_query
	import jcq_pkg::*;
#(
	parameter int MAX_HOLES  = MAX_HOLES_DEF,
	parameter int BLOCK_SIZE = BLOCK_SIZE_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	jcq_stream_if.sink    req,
	jcq_stream_if.source  rsp,
	jcq_stream_if.sink    cfg
);

	localparam int HW = $clog2(MAX_HOLES);
	localparam int CW = HW + 1;
	localparam int JW = $clog2(BLOCK_SIZE + 1);
	localparam int DW = ((HW > FIELD_W) ? HW : FIELD_W) + 1;
	localparam logic [CW-1:0] HC_INIT =
		(HC_RESET > MAX_HOLES) ? CW'(MAX_HOLES) : CW'(HC_RESET);

	typedef struct packed {
		logic [CW-1:0] exit_tgt;
		logic [JW-1:0] jumps;
		logic [HW-1:0] last;
	} sum_t;

	typedef enum logic [3:0] {
		CLR, IDLE, FIND, RB_START, RB_PWR, RB_SUM, RB_WR, Q_RD, Q_USE, DONE
	} state_t;

	logic [FIELD_W-1:0] pwr_mem [MAX_HOLES];
	sum_t               sum_mem [MAX_HOLES];

	state_t             state_q;
	logic [CW-1:0]      hc_q, lo_q, cur_q, jacc_q;
	logic [HW-1:0]      h_q, upd_q, last_q, clr_q;
	logic               all_q, err_q;
	logic [FIELD_W-1:0] pwr_rd_q;
	sum_t               sum_rd_q;
	rsp_t               rsp_data_q;
	logic               rsp_valid_q;

	logic [DW-1:0]      blk_end, dest, rb_hi;
	logic               dest_out, dest_far, pos_bad, blk_last;
	logic [CW-1:0]      cfg_hc;
	logic [HW-1:0]      sum_raddr, pwr_waddr;
	logic               pwr_we, sum_we;
	logic [FIELD_W-1:0] pwr_wdata;
	sum_t               sum_wdata;

	assign blk_end  = DW'(lo_q) + DW'(BLOCK_SIZE);
	assign rb_hi    = (blk_end < DW'(hc_q)) ? blk_end : DW'(hc_q);
	assign dest     = DW'(h_q) + DW'(pwr_rd_q);
	assign dest_out = dest >= DW'(hc_q);
	assign dest_far = dest >= blk_end;
	assign blk_last = DW'(h_q) == DW'(lo_q);
	assign pos_bad  = (req.data.position == '0) || (DW'(req.data.position) > DW'(hc_q));
	assign sum_raddr = (state_q == RB_SUM) ? dest[HW-1:0] : cur_q[HW-1:0];

	always_comb begin
		if (cfg.data == '0)
			cfg_hc = CW'(1);
		else if (DW'(cfg.data) > DW'(MAX_HOLES))
			cfg_hc = CW'(MAX_HOLES);
		else
			cfg_hc = CW'(cfg.data);
	end

	assign cfg.ready = (state_q == IDLE);
	assign req.ready = (state_q == IDLE) && !cfg.valid;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

	// power memory write: clearing sweep or an accepted in-range update
	always_comb begin
		pwr_we    = 1'b0;
		pwr_waddr = clr_q;
		pwr_wdata = FIELD_W'(1);
		if (state_q == CLR) begin
			pwr_we = 1'b1;
		end else if (req.valid && req.ready && req.data.req_type == REQ_SET && !pos_bad) begin
			pwr_we    = 1'b1;
			pwr_waddr = HW'(req.data.position - FIELD_W'(1));
			pwr_wdata = (req.data.power == '0) ? FIELD_W'(1) : req.data.power;
		end
	end

	// summary write for hole h_q
	always_comb begin
		sum_we    = 1'b0;
		sum_wdata = '{exit_tgt: hc_q, jumps: JW'(1), last: h_q};
		case (state_q)
			RB_SUM: begin
				if (dest_out) begin
					sum_we = 1'b1;
				end else if (dest_far) begin
					sum_we = 1'b1;
					sum_wdata.exit_tgt = CW'(dest);
				end
			end
			RB_WR: begin
				sum_we    = 1'b1;
				sum_wdata = '{exit_tgt: sum_rd_q.exit_tgt,
					jumps: sum_rd_q.jumps + JW'(1), last: sum_rd_q.last};
			end
			default: sum_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pwr_we)
			pwr_mem[pwr_waddr] <= pwr_wdata;
		pwr_rd_q <= pwr_mem[h_q];
	end

	always_ff @(posedge clk) begin
		if (sum_we)
			sum_mem[h_q] <= sum_wdata;
		sum_rd_q <= sum_mem[sum_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CLR;
			hc_q        <= HC_INIT;
			clr_q       <= '0;
			all_q       <= 1'b0;
			err_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
			lo_q        <= '0;
		end else begin
			// DONE reloads the output register itself
			if (rsp_valid_q && rsp.ready && state_q != DONE)
				rsp_valid_q <= 1'b0;
			case (state_q)
				CLR: begin
					clr_q <= clr_q + HW'(1);
					if (CW'(clr_q) == CW'(MAX_HOLES - 1)) begin
						lo_q    <= '0;
						all_q   <= 1'b1;
						state_q <= RB_START;
					end
				end
				IDLE: begin
					if (cfg.valid) begin
						hc_q    <= cfg_hc;
						lo_q    <= '0;
						all_q   <= 1'b1;
						state_q <= RB_START;
					end else if (req.valid) begin
						if (req.data.req_type == REQ_SET) begin
							if (!pos_bad) begin
								upd_q   <= HW'(req.data.position - FIELD_W'(1));
								lo_q    <= '0;
								all_q   <= 1'b0;
								state_q <= FIND;
							end
						end else if (pos_bad) begin
							err_q   <= 1'b1;
							state_q <= DONE;
						end else begin
							err_q   <= 1'b0;
							cur_q   <= CW'(req.data.position - FIELD_W'(1));
							last_q  <= HW'(req.data.position - FIELD_W'(1));
							jacc_q  <= '0;
							state_q <= Q_RD;
						end
					end
				end
				FIND: begin
					// step block start until it covers the updated hole
					if (DW'(upd_q) >= blk_end)
						lo_q <= CW'(blk_end);
					else
						state_q <= RB_START;
				end
				RB_START: begin
					h_q     <= HW'(rb_hi - DW'(1));
					state_q <= RB_PWR;
				end
				RB_PWR: state_q <= RB_SUM;
				RB_SUM, RB_WR: begin
					if (state_q == RB_SUM && !dest_out && !dest_far) begin
						state_q <= RB_WR;
					end else if (blk_last) begin
						if (all_q && blk_end < DW'(hc_q)) begin
							lo_q    <= CW'(blk_end);
							state_q <= RB_START;
						end else begin
							state_q <= IDLE;
						end
					end else begin
						h_q     <= h_q - HW'(1);
						state_q <= RB_PWR;
					end
				end
				Q_RD: state_q <= Q_USE;
				Q_USE: begin
					jacc_q  <= jacc_q + CW'(sum_rd_q.jumps);
					last_q  <= sum_rd_q.last;
					cur_q   <= sum_rd_q.exit_tgt;
					state_q <= (sum_rd_q.exit_tgt < hc_q) ? Q_RD : DONE;
				end
				DONE: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q <= 1'b1;
						if (err_q)
							rsp_data_q <= '{last_hole: '0, jump_count: '0, error: 1'b1};
						else
							rsp_data_q <= '{last_hole: FIELD_W'(CW'(last_q) + CW'(1)),
								jump_count: FIELD_W'(jacc_q), error: 1'b0};
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	a_hc_range: assert property (@(posedge clk) disable iff (!arst_n)
		(hc_q != '0) && (DW'(hc_q) <= DW'(MAX_HOLES)))
		else $error("hole count out of range");

	a_query_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == Q_RD) |-> (cur_q < hc_q))
		else $error("query reads an inactive hole");

	a_rebuild_in_block: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == RB_SUM || state_q == RB_WR) |->
			(DW'(h_q) >= DW'(lo_q)) && (DW'(h_q) < blk_end) && (CW'(h_q) < hc_q))
		else $error("rebuild index left its block");

	a_err_fast: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && req.data.req_type == REQ_QUERY && pos_bad)
			|=> (state_q == DONE) && err_q)
		else $error("bad query not answered directly");

endmodule
